// File: rtl/core/bsr_pkg.sv
// Shared types and constants for the bilinear RGBA32 scaler.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package bsr_pkg;

	localparam int PIX_W    = 32;   // four 8-bit channels
	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 4;
	localparam int CHAN_IDX_W = 2;
	localparam int ACC_W    = 28;   // 12.16 accumulator, wraps at 28 bits
	localparam int INT_LSB  = 16;
	localparam int COORD_W  = 12;   // reported source column/row
	localparam int FRAC_W   = 4;    // weight bits taken from the fraction
	localparam int FRAC_LSB = 12;
	localparam int WGT_W    = 9;    // weights run 0..256
	localparam int DIM_W    = 13;   // size registers
	localparam int SUM_W    = 16;   // weighted sum of one channel, max 255*256

	localparam logic [ACC_W-1:0] ONE_ROW = ACC_W'(32'h10000);
	localparam logic [FRAC_W:0]  WGT_ONE = 5'd16;

	// APB
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_HSTEP  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_VSTEP  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DWIDTH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DHEIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SHEIGHT = 3'd4;

	typedef struct packed {
		logic [ACC_W-1:0] horizontal_step;
		logic [ACC_W-1:0] vertical_step;
		logic [DIM_W-1:0] dest_width;
		logic [DIM_W-1:0] dest_height;
		logic [DIM_W-1:0] source_height;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic                  load;   // capture request, advance coordinates
		logic                  mac;    // interpolate one channel
		logic [CHAN_IDX_W-1:0] chan;
		logic                  emit;   // move finished pixel to output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // output register empty or draining this cycle
	} dp_stat_t;

endpackage

// File: rtl/core/bsr_if.sv
// Request and result channel interfaces of the bilinear RGBA32 scaler.
// Depends on bsr_pkg for field widths.
interface bsr_in_if;
	logic                       valid;
	logic                       ready;
	logic [bsr_pkg::PIX_W-1:0]  upper_left;
	logic [bsr_pkg::PIX_W-1:0]  upper_right;
	logic [bsr_pkg::PIX_W-1:0]  lower_left;
	logic [bsr_pkg::PIX_W-1:0]  lower_right;

	modport source (output valid, upper_left, upper_right, lower_left, lower_right,
		input ready);
	modport sink (input valid, upper_left, upper_right, lower_left, lower_right,
		output ready);
endinterface

interface bsr_out_if;
	logic                         valid;
	logic                         ready;
	logic [bsr_pkg::PIX_W-1:0]    pixel;
	logic [bsr_pkg::COORD_W-1:0]  next_src_x;
	logic [bsr_pkg::COORD_W-1:0]  next_src_y;
	logic                         end_of_row;
	logic                         end_of_frame;

	modport source (output valid, pixel, next_src_x, next_src_y, end_of_row,
		end_of_frame, input ready);
	modport sink (input valid, pixel, next_src_x, next_src_y, end_of_row,
		end_of_frame, output ready);
endinterface

// File: rtl/core/bsr_cfg.sv
// APB register file of the scaler: steps and frame sizes.
// Depends on bsr_pkg.
module bsr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bsr_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [bsr_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bsr_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output bsr_pkg::cfg_t                     cfg
);

	bsr_pkg::cfg_t                    cfg_q;
	logic [bsr_pkg::REG_IDX_W-1:0]    idx;
	logic                             wr_en;

	assign idx    = paddr[bsr_pkg::APB_ADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.horizontal_step <= '0;
			cfg_q.vertical_step   <= '0;
			cfg_q.dest_width      <= bsr_pkg::DIM_W'(1);
			cfg_q.dest_height     <= bsr_pkg::DIM_W'(1);
			cfg_q.source_height   <= bsr_pkg::DIM_W'(2);
		end else if (wr_en) begin
			case (idx)
				bsr_pkg::REG_HSTEP:   cfg_q.horizontal_step <= pwdata[bsr_pkg::ACC_W-1:0];
				bsr_pkg::REG_VSTEP:   cfg_q.vertical_step   <= pwdata[bsr_pkg::ACC_W-1:0];
				bsr_pkg::REG_DWIDTH:  cfg_q.dest_width      <= pwdata[bsr_pkg::DIM_W-1:0];
				bsr_pkg::REG_DHEIGHT: cfg_q.dest_height     <= pwdata[bsr_pkg::DIM_W-1:0];
				bsr_pkg::REG_SHEIGHT: cfg_q.source_height   <= pwdata[bsr_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bsr_pkg::REG_HSTEP:   prdata = bsr_pkg::APB_DATA_W'(cfg_q.horizontal_step);
			bsr_pkg::REG_VSTEP:   prdata = bsr_pkg::APB_DATA_W'(cfg_q.vertical_step);
			bsr_pkg::REG_DWIDTH:  prdata = bsr_pkg::APB_DATA_W'(cfg_q.dest_width);
			bsr_pkg::REG_DHEIGHT: prdata = bsr_pkg::APB_DATA_W'(cfg_q.dest_height);
			bsr_pkg::REG_SHEIGHT: prdata = bsr_pkg::APB_DATA_W'(cfg_q.source_height);
			default:              prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/bsr_ctrl.sv
// Controller of the scaler: takes a request, steps the channel unit
// through four channels, then hands the pixel to the output register. Uses bsr_pkg.
module bsr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bsr_pkg::dp_stat_t   stat,
	output bsr_pkg::dp_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MAC  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]                        state_q;
	logic [bsr_pkg::CHAN_IDX_W-1:0]    chan_q;
	logic                              last_chan;

	assign last_chan = (chan_q == bsr_pkg::CHAN_IDX_W'(bsr_pkg::NUM_CHAN - 1));
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.mac  = (state_q == S_MAC);
		cmd.chan = chan_q;
		cmd.emit = (state_q == S_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chan_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					chan_q <= '0;
					if (in_valid) state_q <= S_MAC;
				end
				S_MAC: begin
					chan_q <= chan_q + 1'b1;
					if (last_chan) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/bsr_dp.sv
// Datapath of the scaler: coordinate walk, weights, per-channel
// interpolation unit and the output register. Uses bsr_pkg.
module bsr_dp #(
	parameter int MAX_DIM = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bsr_pkg::cfg_t                     cfg,
	input  bsr_pkg::dp_cmd_t                  cmd,
	output bsr_pkg::dp_stat_t                 stat,
	input  logic [bsr_pkg::PIX_W-1:0]         upper_left,
	input  logic [bsr_pkg::PIX_W-1:0]         upper_right,
	input  logic [bsr_pkg::PIX_W-1:0]         lower_left,
	input  logic [bsr_pkg::PIX_W-1:0]         lower_right,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bsr_pkg::PIX_W-1:0]         pixel,
	output logic [bsr_pkg::COORD_W-1:0]       next_src_x,
	output logic [bsr_pkg::COORD_W-1:0]       next_src_y,
	output logic                              end_of_row,
	output logic                              end_of_frame
);

	localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int EW    = (CNT_W + 1 > bsr_pkg::DIM_W) ? CNT_W + 1 : bsr_pkg::DIM_W;
	localparam int ACC_W = bsr_pkg::ACC_W;
	localparam int CW    = bsr_pkg::CHAN_W;

	// walk state
	logic [ACC_W-1:0]  x_acc_q, y_acc_q;
	logic [CNT_W-1:0]  col_q, row_q;

	// captured request
	logic [bsr_pkg::PIX_W-1:0]  ul_q, ur_q, ll_q, lr_q;
	logic [bsr_pkg::WGT_W-1:0]  w_ul_q, w_ur_q, w_ll_q, w_lr_q;
	logic [bsr_pkg::PIX_W-1:0]  pix_q;
	logic [bsr_pkg::COORD_W-1:0] nx_q, ny_q;
	logic                       eor_q, eof_q;

	// output register
	logic                       ovalid_q;
	logic [bsr_pkg::PIX_W-1:0]  opix_q;
	logic [bsr_pkg::COORD_W-1:0] ox_q, oy_q;
	logic                       oeor_q, oeof_q;

	// ---- effective sizes ----
	logic [EW-1:0] dw_ext, dh_ext, eff_w, eff_h;
	logic [EW-1:0] col_inc, row_inc;
	logic          last_col, last_row;

	assign dw_ext = EW'(cfg.dest_width);
	assign dh_ext = EW'(cfg.dest_height);

	always_comb begin
		if (dw_ext == '0)                eff_w = EW'(1);
		else if (dw_ext > EW'(MAX_DIM))  eff_w = EW'(MAX_DIM);
		else                             eff_w = dw_ext;
		if (dh_ext == '0)                eff_h = EW'(1);
		else if (dh_ext > EW'(MAX_DIM))  eff_h = EW'(MAX_DIM);
		else                             eff_h = dh_ext;
	end

	assign col_inc  = EW'(col_q) + EW'(1);
	assign row_inc  = EW'(row_q) + EW'(1);
	assign last_col = (col_inc >= eff_w);
	assign last_row = (row_inc >= eff_h);

	// ---- next coordinates ----
	logic [ACC_W-1:0]         x_nxt, y_step, y_wrap, y_nxt;
	logic [bsr_pkg::DIM_W-1:0] y_limit;

	always_comb begin
		y_limit = (cfg.source_height < bsr_pkg::DIM_W'(2)) ? bsr_pkg::DIM_W'(1)
			: cfg.source_height - bsr_pkg::DIM_W'(1);
		y_step  = y_acc_q + cfg.vertical_step;
		y_wrap  = last_row ? '0 : y_step;
		// bottom clamp, applied once at row start
		if (bsr_pkg::DIM_W'(y_wrap[ACC_W-1:bsr_pkg::INT_LSB]) >= y_limit)
			y_wrap = y_wrap - bsr_pkg::ONE_ROW;
		x_nxt = last_col ? '0 : (x_acc_q + cfg.horizontal_step);
		y_nxt = last_col ? y_wrap : y_acc_q;
	end

	// ---- weights from the top fraction bits ----
	logic [bsr_pkg::FRAC_W-1:0] fu, fv;
	logic [bsr_pkg::FRAC_W:0]   iu, iv;

	assign fu = x_acc_q[bsr_pkg::FRAC_LSB +: bsr_pkg::FRAC_W];
	assign fv = y_acc_q[bsr_pkg::FRAC_LSB +: bsr_pkg::FRAC_W];
	assign iu = bsr_pkg::WGT_ONE - {1'b0, fu};
	assign iv = bsr_pkg::WGT_ONE - {1'b0, fv};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_acc_q <= '0;
			y_acc_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cmd.load) begin
			x_acc_q <= x_nxt;
			y_acc_q <= y_nxt;
			col_q   <= last_col ? '0 : col_inc[CNT_W-1:0];
			if (last_col)
				row_q <= last_row ? '0 : row_inc[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ul_q   <= upper_left;
			ur_q   <= upper_right;
			ll_q   <= lower_left;
			lr_q   <= lower_right;
			w_ul_q <= bsr_pkg::WGT_W'(iu * iv);
			w_ur_q <= bsr_pkg::WGT_W'({1'b0, fu} * iv);
			w_ll_q <= bsr_pkg::WGT_W'(iu * {1'b0, fv});
			w_lr_q <= bsr_pkg::WGT_W'(fu * fv);
			nx_q   <= x_nxt[ACC_W-1:bsr_pkg::INT_LSB];
			ny_q   <= y_nxt[ACC_W-1:bsr_pkg::INT_LSB];
			eor_q  <= last_col;
			eof_q  <= last_col && last_row;
		end
	end

	// ---- shared channel unit: one channel per cycle ----
	logic [CW-1:0]              a_ul, a_ur, a_ll, a_lr;
	logic [bsr_pkg::SUM_W+1:0]  chan_sum;

	assign a_ul = ul_q[cmd.chan*CW +: CW];
	assign a_ur = ur_q[cmd.chan*CW +: CW];
	assign a_ll = ll_q[cmd.chan*CW +: CW];
	assign a_lr = lr_q[cmd.chan*CW +: CW];

	assign chan_sum = (bsr_pkg::SUM_W+2)'(a_ul * w_ul_q) + (bsr_pkg::SUM_W+2)'(a_ur * w_ur_q)
		+ (bsr_pkg::SUM_W+2)'(a_ll * w_ll_q) + (bsr_pkg::SUM_W+2)'(a_lr * w_lr_q);

	always_ff @(posedge clk) begin
		if (cmd.mac)
			pix_q[cmd.chan*CW +: CW] <= chan_sum[bsr_pkg::SUM_W-1:CW];
	end

	// ---- output register ----
	assign stat.out_free = !ovalid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.emit)
			ovalid_q <= 1'b1;
		else if (out_ready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			opix_q <= pix_q;
			ox_q   <= nx_q;
			oy_q   <= ny_q;
			oeor_q <= eor_q;
			oeof_q <= eof_q;
		end
	end

	assign out_valid    = ovalid_q;
	assign pixel        = opix_q;
	assign next_src_x   = ox_q;
	assign next_src_y   = oy_q;
	assign end_of_row   = oeor_q;
	assign end_of_frame = oeof_q;

endmodule

// File: rtl/core/bilinear_scaler_rgba32_unit.sv
// Bilinear RGBA32 scaler, top level.
// Needs bsr_pkg, bsr_if, bsr_cfg, bsr_ctrl and bsr_dp.
//
// Usage:
//  - pix_in carries one request: the four source neighbours of the position
//    reported by the previous result (position (0,0) after reset or frame end).
//  - pix_out returns one result per request: the interpolated pixel, the source
//    column/row the next request must bring, and end of row / end of frame flags.
//  - Both channels use valid/ready; a transfer happens when both are high.
//  - APB port holds the steps and sizes; write it only while the block is idle.
// Sequencing:
//  - A request is taken in the idle state, the shared channel unit then works
//    through the four channels (one 8-bit channel each pass), and the handoff
//    state moves the pixel into the output register once that register is free.
//  - A new request is taken only after the four passes through the channel unit
//    and the handoff of the previous pixel; requests are handled one at a time.
//  - If the receiver stalls, the finished pixel waits in the datapath while the
//    controller waits in handoff; no request is taken until the output frees up.
//  - Reset clears the walk (coordinates, column, row), the output valid and
//    the registers to steps 0, sizes 1 x 1, source height 2.
module bilinear_scaler_rgba32_unit #(
	parameter int MAX_DIM = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bsr_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [bsr_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bsr_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	bsr_in_if.sink                            pix_in,
	bsr_out_if.source                         pix_out
);

	bsr_pkg::cfg_t      cfg;
	bsr_pkg::dp_cmd_t   cmd;
	bsr_pkg::dp_stat_t  stat;

	// register file
	bsr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencing: idle -> four channel passes -> handoff
	bsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (pix_in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// coordinate walk, interpolation and output register
	bsr_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.upper_left   (pix_in.upper_left),
		.upper_right  (pix_in.upper_right),
		.lower_left   (pix_in.lower_left),
		.lower_right  (pix_in.lower_right),
		.out_valid    (pix_out.valid),
		.out_ready    (pix_out.ready),
		.pixel        (pix_out.pixel),
		.next_src_x   (pix_out.next_src_x),
		.next_src_y   (pix_out.next_src_y),
		.end_of_row   (pix_out.end_of_row),
		.end_of_frame (pix_out.end_of_frame)
	);

endmodule

// File: dv/tb_bilinear_scaler_rgba32_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of bilinear_scaler_rgba32_unit: an in-bench predictor
// of the scaler walk and interpolation checks every result; APB sets the scaling.
// Depends on bsr_pkg, bsr_if and the scaler RTL.
module tb_bilinear_scaler_rgba32_unit;

	localparam int NUM_PHASES = 14;

	typedef struct packed {
		logic [bsr_pkg::PIX_W-1:0]   pixel;
		logic [bsr_pkg::COORD_W-1:0] next_src_x;
		logic [bsr_pkg::COORD_W-1:0] next_src_y;
		logic                        end_of_row;
		logic                        end_of_frame;
	} scaled_pixel_t;

	// Predicts the scaler walk and keeps the expected pixels in request order.
	class scaler_scoreboard;
		logic [bsr_pkg::ACC_W-1:0] hstep, vstep;
		logic [bsr_pkg::DIM_W-1:0] dwidth, dheight, sheight;
		logic [bsr_pkg::ACC_W-1:0] x_acc, y_acc;
		int unsigned      col, row;
		scaled_pixel_t    expected_pixels[$];
		int unsigned      errors, requests, row_ends, frame_ends;

		function new();
			hstep = '0;
			vstep = '0;
			dwidth = 13'd1;
			dheight = 13'd1;
			sheight = 13'd2;
			x_acc = '0;
			y_acc = '0;
			col = 0;
			row = 0;
			errors = 0;
			requests = 0;
			row_ends = 0;
			frame_ends = 0;
		endfunction

		function void set_reg(logic [bsr_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				bsr_pkg::REG_HSTEP:   hstep = val[bsr_pkg::ACC_W-1:0];
				bsr_pkg::REG_VSTEP:   vstep = val[bsr_pkg::ACC_W-1:0];
				bsr_pkg::REG_DWIDTH:  dwidth = val[bsr_pkg::DIM_W-1:0];
				bsr_pkg::REG_DHEIGHT: dheight = val[bsr_pkg::DIM_W-1:0];
				bsr_pkg::REG_SHEIGHT: sheight = val[bsr_pkg::DIM_W-1:0];
				default: ;
			endcase
		endfunction

		// 0 acts as 1, anything past 4096 as 4096
		function int unsigned eff_size(logic [bsr_pkg::DIM_W-1:0] s);
			if (s == 0)
				return 1;
			if (s > 4096)
				return 4096;
			return s;
		endfunction

		function void take_request(logic [bsr_pkg::PIX_W-1:0] ul,
				logic [bsr_pkg::PIX_W-1:0] ur, logic [bsr_pkg::PIX_W-1:0] ll,
				logic [bsr_pkg::PIX_W-1:0] lr);
			int unsigned fu, fv, w_ul, w_ur, w_ll, w_lr, sum, limit;
			scaled_pixel_t exp_px;
			fu = x_acc[bsr_pkg::FRAC_LSB +: bsr_pkg::FRAC_W];
			fv = y_acc[bsr_pkg::FRAC_LSB +: bsr_pkg::FRAC_W];
			w_ul = (16 - fu) * (16 - fv);
			w_ur = fu * (16 - fv);
			w_ll = (16 - fu) * fv;
			w_lr = fu * fv;
			exp_px = '0;
			for (int k = 0; k < bsr_pkg::NUM_CHAN; k++) begin
				sum = ul[8*k +: 8] * w_ul + ur[8*k +: 8] * w_ur
					+ ll[8*k +: 8] * w_ll + lr[8*k +: 8] * w_lr;
				exp_px.pixel[8*k +: 8] = sum[15:8];
			end
			x_acc = x_acc + hstep;
			col++;
			if (col >= eff_size(dwidth)) begin
				exp_px.end_of_row = 1'b1;
				col = 0;
				x_acc = '0;
				y_acc = y_acc + vstep;
				row++;
				if (row >= eff_size(dheight)) begin
					exp_px.end_of_frame = 1'b1;
					row = 0;
					y_acc = '0;
				end
				// bottom clamp: step back one source row, only at row start
				limit = (sheight < 2) ? 1 : sheight - 1;
				if (y_acc[bsr_pkg::ACC_W-1:bsr_pkg::INT_LSB] >= limit)
					y_acc = y_acc - bsr_pkg::ONE_ROW;
			end
			exp_px.next_src_x = x_acc[bsr_pkg::INT_LSB +: bsr_pkg::COORD_W];
			exp_px.next_src_y = y_acc[bsr_pkg::INT_LSB +: bsr_pkg::COORD_W];
			expected_pixels.push_back(exp_px);
			requests++;
		endfunction

		function void check_pixel(scaled_pixel_t got);
			scaled_pixel_t want;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			row_ends += got.end_of_row;
			frame_ends += got.end_of_frame;
			if (got.pixel !== want.pixel) begin
				$display("%0t: pixel expected %h actual %h", $time, want.pixel, got.pixel);
				errors++;
			end
			if (got.next_src_x !== want.next_src_x) begin
				$display("%0t: next_src_x expected %0d actual %0d", $time,
					want.next_src_x, got.next_src_x);
				errors++;
			end
			if (got.next_src_y !== want.next_src_y) begin
				$display("%0t: next_src_y expected %0d actual %0d", $time,
					want.next_src_y, got.next_src_y);
				errors++;
			end
			if (got.end_of_row !== want.end_of_row) begin
				$display("%0t: end_of_row expected %b actual %b", $time,
					want.end_of_row, got.end_of_row);
				errors++;
			end
			if (got.end_of_frame !== want.end_of_frame) begin
				$display("%0t: end_of_frame expected %b actual %b", $time,
					want.end_of_frame, got.end_of_frame);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           psel, penable, pwrite;
	logic [bsr_pkg::APB_ADDR_W-1:0] paddr;
	logic [bsr_pkg::APB_DATA_W-1:0] pwdata, prdata;
	logic                           pready;

	bsr_in_if  pix_in();
	bsr_out_if pix_out();

	scaler_scoreboard sb;
	int unsigned      send_idle, recv_idle;   // percent of cycles spent idle
	int unsigned      cfg_errors;

	bilinear_scaler_rgba32_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Register write with setup and access cycles, then a readback of the same register.
	task automatic apb_write(logic [bsr_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== val) begin
			$display("%0t: register %0d readback expected %h actual %h", $time,
				idx, val, prdata);
			cfg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_scaling(logic [bsr_pkg::ACC_W-1:0] h, logic [bsr_pkg::ACC_W-1:0] v,
			logic [bsr_pkg::DIM_W-1:0] dw, logic [bsr_pkg::DIM_W-1:0] dh,
			logic [bsr_pkg::DIM_W-1:0] sh);
		apb_write(bsr_pkg::REG_HSTEP, 32'(h));
		apb_write(bsr_pkg::REG_VSTEP, 32'(v));
		apb_write(bsr_pkg::REG_DWIDTH, 32'(dw));
		apb_write(bsr_pkg::REG_DHEIGHT, 32'(dh));
		apb_write(bsr_pkg::REG_SHEIGHT, 32'(sh));
	endtask

	// One request; random idle cycles in front of it. valid stays up after
	// acceptance so back-to-back requests never toggle it within one step.
	task automatic send_request(logic [bsr_pkg::PIX_W-1:0] ul, logic [bsr_pkg::PIX_W-1:0] ur,
			logic [bsr_pkg::PIX_W-1:0] ll, logic [bsr_pkg::PIX_W-1:0] lr);
		while ($urandom_range(99) < send_idle) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.upper_left <= ul;
		pix_in.upper_right <= ur;
		pix_in.lower_left <= ll;
		pix_in.lower_right <= lr;
		do @(posedge clk); while (!pix_in.ready);
		sb.take_request(ul, ur, ll, lr);
	endtask

	// Sender holds off until every predicted pixel has come back.
	task automatic drain();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [bsr_pkg::PIX_W-1:0] rand_px();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_request();
		send_request(rand_px(), rand_px(), rand_px(), rand_px());
	endtask

	// Result side: check on every handshake, pick ready for the next cycle.
	initial begin
		pix_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pix_out.valid && pix_out.ready)
				sb.check_pixel({pix_out.pixel, pix_out.next_src_x, pix_out.next_src_y,
					pix_out.end_of_row, pix_out.end_of_frame});
			pix_out.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		int unsigned n_items, sw, shs, dw, dh;
		logic [bsr_pkg::ACC_W-1:0] h, v;

		sb = new();
		cfg_errors = 0;
		send_idle = 30;
		recv_idle = 76;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_in.valid = 1'b0;
		pix_in.upper_left = '0;
		pix_in.upper_right = '0;
		pix_in.lower_left = '0;
		pix_in.lower_right = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset scaling: 1 x 1 frame, zero steps, so each result is upper_left
		// and flags both row and frame end.
		send_request('0, '0, '0, '0);
		send_request('1, '1, '1, '1);
		send_request('1, '0, '0, '0);
		send_request('0, '1, '1, '1);
		send_request(32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF);
		send_request(32'h80808080, 32'h7F7F7F7F, 32'h01010101, 32'hFEFEFEFE);
		drain();

		// Step 1/16 pixel: the first row sweeps every horizontal weight. Second
		// row lands on source row 1 and gets clamped back, all vertical weight 15.
		set_scaling(bsr_pkg::ACC_W'(32'h1000), bsr_pkg::ACC_W'(32'h1F000), 13'd16, 13'd3,
			13'd2);
		for (int i = 0; i < 18; i++)
			send_request((i % 3 == 0) ? '1 : rand_px(), rand_px(), rand_px(),
				(i % 4 == 1) ? '0 : rand_px());
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			// first sender-light/receiver-heavy idling, then swapped, then none
			if (p < 5) begin
				send_idle = 30;
				recv_idle = 76;
			end else if (p < 10) begin
				send_idle = 76;
				recv_idle = 30;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			n_items = $urandom_range(60, 85);
			case (p)
				// steps wrap past the 28-bit accumulator, source height past MAX_DIM
				0: set_scaling('1, '1, 13'd3, 13'd5, 13'd8191);
				// largest legal steps, zero width, source height under 2
				1: set_scaling(bsr_pkg::ACC_W'(268369920), bsr_pkg::ACC_W'(268369920),
					13'd0, 13'd4, 13'd1);
				// width past MAX_DIM: kept short, the row never ends here
				2: begin
					set_scaling(bsr_pkg::ACC_W'(32'h100), bsr_pkg::ACC_W'(32'h10000),
						13'd8191, 13'd2, 13'd0);
					n_items = 30;
				end
				// every pixel ends a row of a 4096-row frame
				3: set_scaling(bsr_pkg::ACC_W'(32'h18000), bsr_pkg::ACC_W'(32'h2C000),
					13'd1, 13'd4096, 13'd4096);
				4: begin
					set_scaling('0, '0, 13'd4096, 13'd0, 13'd3);
					n_items = 30;
				end
				default: begin
					if ($urandom_range(1)) begin
						// what software programs: ((src - 1) << 16) / dst
						sw = $urandom_range(2, 64);
						shs = $urandom_range(2, 64);
						dw = $urandom_range(1, 16);
						dh = $urandom_range(1, 8);
						h = bsr_pkg::ACC_W'(((sw - 1) << 16) / dw);
						v = bsr_pkg::ACC_W'(((shs - 1) << 16) / dh);
					end else begin
						// oversized vertical steps on short sources hit the clamp
						shs = $urandom_range(0, 8);
						dw = $urandom_range(1, 12);
						dh = $urandom_range(1, 6);
						h = bsr_pkg::ACC_W'($urandom_range(0, 32'h40000));
						v = bsr_pkg::ACC_W'($urandom_range(0, 32'h60000));
					end
					set_scaling(h, v, bsr_pkg::DIM_W'(dw), bsr_pkg::DIM_W'(dh),
						bsr_pkg::DIM_W'(shs));
				end
			endcase
			for (int i = 0; i < n_items; i++) begin
				send_random_request();
				// one mid-phase hold-off until all pending results are back
				if (p == 7 && i == n_items / 2)
					drain();
			end
			drain();
		end

		pix_in.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("Checked %0d requests over %0d scaling setups: %0d row ends, %0d frame ends.",
			sb.requests, NUM_PHASES + 2, sb.row_ends, sb.frame_ends);
		$display("Steps and sizes swept through zero, wrap and clamp extremes; %0d leftover.",
			sb.pending());
		if (sb.errors == 0 && cfg_errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
